FILE: sv/dls_pkg.sv
// Package for the doubly linked list store.
// Holds the operation and status codes and the fixed field widths.
// No dependencies.
`default_nettype none

package dls_pkg;

   // Field widths of the item channels
   localparam int ACTION_W = 3;
   localparam int KEY_W    = 32;
   localparam int POS_W    = 10;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 11;
   localparam int REQ_W    = 48;
   localparam int RSP_W    = 48;

   // Operation codes
   localparam logic [ACTION_W-1:0] ACT_INSERT    = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_DEL_KEY   = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_DEL_FIRST = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_DEL_LAST  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_READ      = 3'd4;

   // Status codes
   localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STS_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] STS_RANGE     = 2'd3;

   typedef logic [KEY_W-1:0] key_type;

endpackage

`default_nettype wire

FILE: sv/dls_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dls_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

FILE: sv/doubly_linked_list_store.sv
// Doubly linked list store: one result item per request item.
// Rejected ops and unused codes answer from idle; insert writes the new head, then
// relinks the old head; deletes unlink the entry once found; reads walk to the position.
// One item at a time; the link walk does one memory read per cycle (up to CAPACITY).
// Reset (synchronous) empties the list: head/tail registers point at the sentinel.
// Depends on dls_pkg and dls_ram.
`default_nettype none

module doubly_linked_list_store
   import dls_pkg::*;
#(
   parameter int CAPACITY = 1024
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,  // action[2:0], key[34:3], position[44:35]
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic      [RSP_W-1:0] rsp_tdata   // status[1:0], key_out[33:2], count[44:34]
);

   localparam int IW = $clog2(CAPACITY);
   localparam int LW = $clog2(CAPACITY + 1);
   localparam logic [LW-1:0] SENT = LW'(CAPACITY);
   localparam logic [LW-1:0] ONE  = LW'(1);

   // Sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_POP    = 3'd1;
   localparam logic [2:0] S_INS1   = 3'd2;
   localparam logic [2:0] S_INS2   = 3'd3;
   localparam logic [2:0] S_UNLINK = 3'd4;
   localparam logic [2:0] S_SEARCH = 3'd5;
   localparam logic [2:0] S_READ   = 3'd6;

   // Request fields
   logic [ACTION_W-1:0] req_action;
   key_type             req_key;
   logic [POS_W-1:0]    req_pos;
   assign req_action = req_tdata[ACTION_W-1:0];
   assign req_key    = req_tdata[ACTION_W+KEY_W-1:ACTION_W];
   assign req_pos    = req_tdata[ACTION_W+KEY_W+POS_W-1:ACTION_W+KEY_W];

   // Control registers
   logic [2:0]       state_ff, state_in;
   logic [LW-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic [LW-1:0]    count_ff, count_in;
   logic [LW-1:0]    free_top_ff, free_top_in, fresh_ff, fresh_in;
   logic             rsp_valid_ff, rsp_valid_in;
   // Payload registers
   logic [LW-1:0]    cur_ff, cur_in, aux_ff, aux_in;
   logic [POS_W-1:0] remain_ff, remain_in;
   key_type          key_ff, key_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   key_type          rsp_key_ff, rsp_key_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   // Memory ports
   logic          key_we, next_we, prev_we, fs_we;
   logic [IW-1:0] key_wa, next_wa, prev_wa, fs_wa, rd_addr, fs_ra;
   key_type       key_wd, key_rd;
   logic [LW-1:0] next_wd, prev_wd, next_rd, prev_rd;
   logic [IW-1:0] fs_wd, fs_rd;

   logic                  accept, finish;
   logic [LW+POS_W-1:0]   pos_ext, cnt_ext;
   logic [LW+COUNT_W-1:0] cnt_out_ext;

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign pos_ext    = {{LW{1'b0}}, req_pos};
   assign cnt_ext    = {{POS_W{1'b0}}, count_ff};

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      free_top_in   = free_top_ff;
      fresh_in      = fresh_ff;
      cur_in        = cur_ff;
      aux_in        = aux_ff;
      remain_in     = remain_ff;
      key_in        = key_ff;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      finish        = 1'b0;
      rd_addr       = cur_ff[IW-1:0];
      fs_ra         = free_top_ff[IW-1:0] - IW'(1);
      key_we  = 1'b0; key_wa  = cur_ff[IW-1:0]; key_wd  = key_ff;
      next_we = 1'b0; next_wa = cur_ff[IW-1:0]; next_wd = head_ff;
      prev_we = 1'b0; prev_wa = cur_ff[IW-1:0]; prev_wd = SENT;
      fs_we   = 1'b0; fs_wa   = free_top_ff[IW-1:0]; fs_wd = cur_ff[IW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               key_in        = req_key;
               rsp_status_in = STS_OK;
               rsp_key_in    = '0;
               case (req_action)
                  ACT_INSERT: begin
                     if (count_ff >= SENT) begin
                        rsp_status_in = STS_FULL;
                        finish        = 1'b1;
                     end else if (free_top_ff != '0) begin
                        free_top_in = free_top_ff - ONE;
                        state_in    = S_POP;
                     end else begin
                        cur_in   = fresh_ff;
                        fresh_in = fresh_ff + ONE;
                        state_in = S_INS1;
                     end
                  end
                  ACT_DEL_KEY, ACT_DEL_FIRST, ACT_DEL_LAST: begin
                     if (count_ff == '0) begin
                        rsp_status_in = STS_NOT_FOUND;
                        finish        = 1'b1;
                     end else begin
                        cur_in   = (req_action == ACT_DEL_LAST) ? tail_ff : head_ff;
                        rd_addr  = cur_in[IW-1:0];
                        state_in = (req_action == ACT_DEL_KEY) ? S_SEARCH : S_UNLINK;
                     end
                  end
                  ACT_READ: begin
                     if (pos_ext >= cnt_ext) begin
                        rsp_status_in = STS_RANGE;
                        finish        = 1'b1;
                     end else begin
                        cur_in    = head_ff;
                        rd_addr   = head_ff[IW-1:0];
                        remain_in = req_pos;
                        state_in  = S_READ;
                     end
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
         end
         S_POP: begin
            cur_in   = {{(LW-IW){1'b0}}, fs_rd};
            state_in = S_INS1;
         end
         S_INS1: begin
            // New entry at the head, links back to the sentinel
            key_we   = 1'b1;
            next_we  = 1'b1;
            prev_we  = 1'b1;
            aux_in   = head_ff;
            head_in  = cur_ff;
            count_in = count_ff + ONE;
            if (head_ff == SENT) begin
               tail_in = cur_ff;
               finish  = 1'b1;
            end else begin
               state_in = S_INS2;
            end
         end
         S_INS2: begin
            // Old head points back at the new entry
            prev_we = 1'b1;
            prev_wa = aux_ff[IW-1:0];
            prev_wd = cur_ff;
            finish  = 1'b1;
         end
         S_SEARCH: begin
            if (key_rd == key_ff) begin
               state_in = S_UNLINK;
            end else if (next_rd == SENT) begin
               rsp_status_in = STS_NOT_FOUND;
               finish        = 1'b1;
            end else begin
               cur_in  = next_rd;
               rd_addr = next_rd[IW-1:0];
            end
         end
         S_READ: begin
            if (remain_ff == '0) begin
               rsp_key_in = key_rd;
               finish     = 1'b1;
            end else begin
               cur_in    = next_rd;
               rd_addr   = next_rd[IW-1:0];
               remain_in = remain_ff - POS_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Unlink cur: read data holds its next and prev links
      if (state_ff == S_UNLINK || (state_ff == S_SEARCH && key_rd == key_ff)) begin
         if (prev_rd == SENT) begin
            head_in = next_rd;
         end else begin
            next_we = 1'b1;
            next_wa = prev_rd[IW-1:0];
            next_wd = next_rd;
         end
         if (next_rd == SENT) begin
            tail_in = prev_rd;
         end else begin
            prev_we = 1'b1;
            prev_wa = next_rd[IW-1:0];
            prev_wd = prev_rd;
         end
         fs_we       = 1'b1;
         free_top_in = free_top_ff + ONE;
         count_in    = count_ff - ONE;
         finish      = 1'b1;
      end

      if (finish) begin
         state_in     = S_IDLE;
         rsp_valid_in = 1'b1;
      end
   end

   assign cnt_out_ext  = {{COUNT_W{1'b0}}, count_in};
   assign rsp_count_in = finish ? cnt_out_ext[COUNT_W-1:0] : rsp_count_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= SENT;
         tail_ff      <= SENT;
         count_ff     <= '0;
         free_top_ff  <= '0;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         free_top_ff  <= free_top_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      aux_ff        <= aux_in;
      remain_ff     <= remain_in;
      key_ff        <= key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-STATUS_W-KEY_W-COUNT_W){1'b0}},
                        rsp_count_ff, rsp_key_ff, rsp_status_ff};

   // Memories
   dls_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key (
      .clock(clock), .wr_en(key_we), .wr_addr(key_wa), .wr_data(key_wd),
      .rd_addr(rd_addr), .rd_data(key_rd));

   dls_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_next (
      .clock(clock), .wr_en(next_we), .wr_addr(next_wa), .wr_data(next_wd),
      .rd_addr(rd_addr), .rd_data(next_rd));

   dls_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_prev (
      .clock(clock), .wr_en(prev_we), .wr_addr(prev_wa), .wr_data(prev_wd),
      .rd_addr(rd_addr), .rd_data(prev_rd));

   dls_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_free (
      .clock(clock), .wr_en(fs_we), .wr_addr(fs_wa), .wr_data(fs_wd),
      .rd_addr(fs_ra), .rd_data(fs_rd));

endmodule

`default_nettype wire

FILE: sv/dls_check.sv
// Port-level checker for the doubly linked list store, bound to the top level.
// Depends on dls_pkg and doubly_linked_list_store.
`default_nettype none

module dls_check
   import dls_pkg::*;
#(
   parameter int CAPACITY = 1024
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_tvalid,
   input wire logic             req_tready,
   input wire logic [REQ_W-1:0] req_tdata,
   input wire logic             rsp_tvalid,
   input wire logic             rsp_tready,
   input wire logic [RSP_W-1:0] rsp_tdata
);

   logic [STATUS_W-1:0] status;
   key_type             key_out;
   logic [COUNT_W-1:0]  count;

   assign status     = rsp_tdata[STATUS_W-1:0];
   assign key_out    = rsp_tdata[STATUS_W+KEY_W-1:STATUS_W];
   assign count      = rsp_tdata[STATUS_W+KEY_W+COUNT_W-1:STATUS_W+KEY_W];

   // A waiting item is held
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item dropped or changed while stalled");

   // Full status only when the list is at capacity
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status == STS_FULL |-> count == COUNT_W'(CAPACITY))
      else $error("full status below capacity");

   // A key is returned only by a successful read
   a_key: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && key_out != '0 |-> status == STS_OK)
      else $error("key_out set on failed op");

   // A request is taken only when the result slot is free or draining
   a_seq: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> !rsp_tvalid || rsp_tready)
      else $error("request accepted while a result is stuck");

endmodule

bind doubly_linked_list_store dls_check #(.CAPACITY(CAPACITY)) u_dls_check (
   .clock(clock), .reset(reset),
   .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));

`default_nettype wire
